FILE: sv/ppc_pkg.sv
package ppc_pkg;

  // Widths of the item fields on the ports.
  localparam int unsigned TARGET_W = 12;
  localparam int unsigned OUT_W    = 13;

  // Largest target the port can carry.
  localparam int unsigned TARGET_PORT_MAX = (2 ** TARGET_W) - 1;

  // Default bound on the target. Larger targets are clamped to it.
  localparam int unsigned MAX_TARGET_DEF = 4095;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SV_RD,
    ST_SV_CHK,
    ST_SV_MARK,
    ST_MOD_RD,
    ST_MOD_CHK,
    ST_CLR,
    ST_DP_RD,
    ST_DP_CHK,
    ST_DP_RDW,
    ST_DP_WR,
    ST_FIN_RD,
    ST_FIN
  } state_e;

endpackage

FILE: sv/ppc_flag_ram.sv
module ppc_flag_ram #(
  parameter int unsigned AW    = 13,
  parameter int unsigned DEPTH = 8191
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/ppc_ways_ram.sv
module ppc_ways_ram #(
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports. A read in the cycle of a write to the same
  // entry returns the old data; the sequencer never uses such a read.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: sv/ppc_mod_add.sv
module ppc_mod_add #(
  parameter int unsigned VW = 13
) (
  input  logic [VW-1:0] a_i,
  input  logic [VW-1:0] b_i,
  input  logic [VW-1:0] mod_i,
  output logic [VW-1:0] sum_o
);

  logic [VW:0] raw;

  // Both operands are already below the modulus, so one subtraction suffices.
  always_comb begin
    raw = {1'b0, a_i} + {1'b0, b_i};
    if (raw >= {1'b0, mod_i}) begin
      sum_o = VW'(raw - {1'b0, mod_i});
    end else begin
      sum_o = raw[VW-1:0];
    end
  end

endmodule

FILE: sv/prime_partition_count_mod_core.sv
// Prime partition counter.
// A transaction on the input channel (in_valid_i, in_stall_o, target_i)
// carries one number n. The block answers with one transaction on the output
// channel (out_valid_o, out_stall_i): count_residue_o is the number of ways to
// write n as a sum of two or more primes, order ignored, modulo modulus_o,
// the smallest prime above n. Targets above MAX_TARGET are clamped to it.
// One transaction is worked at a time; in_stall_o is high from acceptance
// until the result has been moved into the output register. The work runs
// as a sieve up to max(2n, 2) and a search for the modulus, a clear of the
// table, and then, for every prime coin below n, a pass over the table
// entries that reads both operands of each entry and then writes the
// reduced sum.
// Reset returns the sequencer to idle and drops out_valid_o; the memories
// are not cleared, since every transaction rewrites what it reads.
// A held result waits in the output register while out_stall_i is high;
// the next transaction can be accepted and worked meanwhile, and it only
// pauses at its final step until the register is free.
module prime_partition_count_mod_core #(
  parameter int unsigned MAX_TARGET = ppc_pkg::MAX_TARGET_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ppc_pkg::TARGET_W-1:0] target_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ppc_pkg::OUT_W-1:0]    count_residue_o,
  output logic [ppc_pkg::OUT_W-1:0]    modulus_o
);

  import ppc_pkg::*;

  // Effective bound: the port cannot carry more than TARGET_PORT_MAX.
  localparam int unsigned EFF = (MAX_TARGET < TARGET_PORT_MAX) ? MAX_TARGET : TARGET_PORT_MAX;
  localparam int unsigned NW  = $clog2(EFF + 1);
  localparam int unsigned SD  = 2 * EFF + 1;
  localparam int unsigned SW  = $clog2(SD);
  localparam int unsigned WD  = EFF + 1;

  state_e state_q, state_d;

  logic [NW-1:0] n_q, n_d;
  logic [SW-1:0] limit_q, limit_d;
  logic [SW-1:0] a_q, a_d;
  logic [SW:0]   sq_q, sq_d;
  logic [SW:0]   m_q, m_d;
  logic [SW:0]   p_q, p_d;
  logic [NW:0]   j_q, j_d;
  logic [SW-1:0] mod_q, mod_d;

  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] cnt_out_q, cnt_out_d;
  logic [OUT_W-1:0] mod_out_q, mod_out_d;

  logic          in_acc;
  logic          fin_fire;
  logic [NW-1:0] n_in;
  logic [SW-1:0] limit_in;
  logic [SW:0]   m_plus_a;
  logic [SW:0]   sq_next;
  logic          j_gt_n;
  logic [NW:0]   jp_diff;
  logic          p_in_range;

  // Memory and adder controls.
  logic          flag_we;
  logic [SW-1:0] flag_waddr;
  logic          flag_wdata;
  logic [SW-1:0] flag_raddr;
  logic          flag_rd;

  logic          ways_we;
  logic [NW-1:0] ways_waddr;
  logic [SW-1:0] ways_wdata;
  logic [NW-1:0] ways_raddr_a;
  logic [NW-1:0] ways_raddr_b;
  logic [SW-1:0] ways_rd_a;
  logic [SW-1:0] ways_rd_b;
  logic [SW-1:0] mod_sum;

  assign in_stall_o      = (state_q != ST_IDLE);
  assign in_acc          = in_valid_i && !in_stall_o;
  assign fin_fire        = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o     = out_valid_q;
  assign count_residue_o = cnt_out_q;
  assign modulus_o       = mod_out_q;

  // Clamp the incoming target and derive the sieve limit max(2n, 2).
  always_comb begin
    if (32'(target_i) > EFF) begin
      n_in = NW'(EFF);
    end else begin
      n_in = NW'(target_i);
    end
    if (n_in < NW'(2)) begin
      limit_in = SW'(2);
    end else begin
      limit_in = SW'({n_in, 1'b0});
    end
  end

  assign m_plus_a   = m_q + (SW+1)'(a_q);
  assign sq_next    = sq_q + {a_q, 1'b0} + (SW+1)'(1);
  assign j_gt_n     = (j_q > {1'b0, n_q});
  assign jp_diff    = j_q - p_q[NW:0];
  assign p_in_range = (p_q <= {1'b0, limit_q});

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (m_q == {1'b0, limit_q}) state_d = ST_SV_RD;
      end
      ST_SV_RD: begin
        if (sq_q > {1'b0, limit_q}) state_d = ST_MOD_RD;
        else state_d = ST_SV_CHK;
      end
      ST_SV_CHK: begin
        state_d = flag_rd ? ST_SV_MARK : ST_SV_RD;
      end
      ST_SV_MARK: begin
        if (m_plus_a > {1'b0, limit_q}) state_d = ST_SV_RD;
      end
      ST_MOD_RD: begin
        state_d = p_in_range ? ST_MOD_CHK : ST_CLR;
      end
      ST_MOD_CHK: begin
        state_d = flag_rd ? ST_CLR : ST_MOD_RD;
      end
      ST_CLR: begin
        if (j_q == {1'b0, n_q}) state_d = ST_DP_RD;
      end
      ST_DP_RD: begin
        if (p_q >= (SW+1)'(n_q)) state_d = ST_FIN_RD;
        else state_d = ST_DP_CHK;
      end
      ST_DP_CHK: begin
        state_d = flag_rd ? ST_DP_RDW : ST_DP_RD;
      end
      ST_DP_RDW: begin
        state_d = j_gt_n ? ST_DP_RD : ST_DP_WR;
      end
      ST_DP_WR: begin
        state_d = ST_DP_RDW;
      end
      ST_FIN_RD: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_fire) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory and adder controls decoded from the state.
  always_comb begin
    flag_we      = 1'b0;
    flag_waddr   = m_q[SW-1:0];
    flag_wdata   = 1'b0;
    flag_raddr   = a_q;
    ways_we      = 1'b0;
    ways_waddr   = j_q[NW-1:0];
    ways_wdata   = mod_sum;
    ways_raddr_a = n_q;
    ways_raddr_b = n_q;
    case (state_q)
      ST_INIT: begin
        flag_we    = 1'b1;
        flag_wdata = (m_q >= (SW+1)'(2));
      end
      ST_SV_MARK: begin
        flag_we = 1'b1;
      end
      ST_MOD_RD: begin
        flag_raddr = p_in_range ? p_q[SW-1:0] : limit_q;
      end
      ST_DP_RD: begin
        flag_raddr = p_q[SW-1:0];
      end
      ST_CLR: begin
        ways_we    = 1'b1;
        ways_wdata = (j_q == '0) ? SW'(1) : '0;
      end
      ST_DP_RDW: begin
        ways_raddr_a = j_gt_n ? n_q : j_q[NW-1:0];
        ways_raddr_b = jp_diff[NW-1:0];
      end
      ST_DP_WR: begin
        ways_we = 1'b1;
      end
      default: begin
        flag_we = 1'b0;
      end
    endcase
  end

  // Counter and result updates.
  always_comb begin
    n_d         = n_q;
    limit_d     = limit_q;
    a_d         = a_q;
    sq_d        = sq_q;
    m_d         = m_q;
    p_d         = p_q;
    j_d         = j_q;
    mod_d       = mod_q;
    out_valid_d = out_valid_q;
    cnt_out_d   = cnt_out_q;
    mod_out_d   = mod_out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d     = n_in;
          limit_d = limit_in;
          m_d     = '0;
          mod_d   = SW'(2);
        end
      end
      ST_INIT: begin
        m_d  = m_q + (SW+1)'(1);
        a_d  = SW'(2);
        sq_d = (SW+1)'(4);
      end
      ST_SV_RD: begin
        p_d = (SW+1)'(n_q) + (SW+1)'(1);
        j_d = '0;
      end
      ST_SV_CHK: begin
        if (flag_rd) begin
          m_d = sq_q;
        end else begin
          a_d  = a_q + SW'(1);
          sq_d = sq_next;
        end
      end
      ST_SV_MARK: begin
        m_d = m_plus_a;
        if (m_plus_a > {1'b0, limit_q}) begin
          a_d  = a_q + SW'(1);
          sq_d = sq_next;
        end
      end
      ST_MOD_CHK: begin
        if (flag_rd) begin
          mod_d = p_q[SW-1:0];
        end else begin
          p_d = p_q + (SW+1)'(1);
        end
      end
      ST_CLR: begin
        j_d = j_q + (NW+1)'(1);
        p_d = (SW+1)'(2);
      end
      ST_DP_CHK: begin
        if (flag_rd) begin
          j_d = p_q[NW:0];
        end else begin
          p_d = p_q + (SW+1)'(1);
        end
      end
      ST_DP_RDW: begin
        if (j_gt_n) p_d = p_q + (SW+1)'(1);
      end
      ST_DP_WR: begin
        j_d = j_q + (NW+1)'(1);
      end
      ST_FIN: begin
        if (fin_fire) begin
          out_valid_d = 1'b1;
          cnt_out_d   = (n_q == '0) ? '0 : OUT_W'(ways_rd_a);
          mod_out_d   = OUT_W'(mod_q);
        end
      end
      default: begin
        n_d = n_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    limit_q   <= limit_d;
    a_q       <= a_d;
    sq_q      <= sq_d;
    m_q       <= m_d;
    p_q       <= p_d;
    j_q       <= j_d;
    mod_q     <= mod_d;
    cnt_out_q <= cnt_out_d;
    mod_out_q <= mod_out_d;
  end

  ppc_flag_ram #(
    .AW    (SW),
    .DEPTH (SD)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rd)
  );

  ppc_ways_ram #(
    .AW    (NW),
    .DW    (SW),
    .DEPTH (WD)
  ) u_ways_ram (
    .clk_i     (clk_i),
    .we_i      (ways_we),
    .waddr_i   (ways_waddr),
    .wdata_i   (ways_wdata),
    .raddr_a_i (ways_raddr_a),
    .raddr_b_i (ways_raddr_b),
    .rdata_a_o (ways_rd_a),
    .rdata_b_o (ways_rd_b)
  );

  ppc_mod_add #(
    .VW (SW)
  ) u_mod_add (
    .a_i   (ways_rd_a),
    .b_i   (ways_rd_b),
    .mod_i (mod_q),
    .sum_o (mod_sum)
  );

`ifndef NO_ASSERTIONS
  // A delivered count is always a proper residue of its modulus.
  a_residue_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_residue_o < modulus_o))
    else $error("count residue not below modulus");

  // Every table write during the coin pass stays reduced.
  a_dp_write_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DP_WR) |-> (ways_wdata < mod_q))
    else $error("table entry not reduced");

  // Sieve marking never strays past the limit of this transaction.
  a_mark_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SV_MARK) |-> (m_q <= {1'b0, limit_q}))
    else $error("sieve mark beyond limit");

  // The modulus chosen before the table pass lies above the target.
  a_mod_above_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> (mod_q > SW'(n_q)))
    else $error("modulus not above target");
`endif

endmodule

FILE: verif/prime_partition_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the prime partition counter. Every target that is
// accepted is worked out here and queued; every result that leaves the block
// is compared with the oldest queued answer.
module prime_partition_checker
  import ppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [TARGET_W-1:0] target_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [OUT_W-1:0]    count_residue_i,
  input  logic [OUT_W-1:0]    modulus_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned MAX_TARGET   = MAX_TARGET_DEF;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [OUT_W-1:0]    residue;
    logic [OUT_W-1:0]    modulus;
  } answer_t;

  bit          is_prime [0:2*MAX_TARGET+1];
  int unsigned ways     [0:MAX_TARGET];
  answer_t     answers  [$];
  answer_t     head;

  // Sieve up to 2n, take the first prime above n as the modulus, then run the
  // coin-change table with every prime below n as a coin.
  function automatic answer_t count_prime_partitions(input logic [TARGET_W-1:0] target);
    int unsigned n, top, p, m, j, md, s;
    answer_t     a;
    n = target;
    if (n > MAX_TARGET) n = MAX_TARGET;
    top = (2 * n < 2) ? 2 : 2 * n;
    for (p = 0; p <= top; p++) is_prime[p] = (p >= 2);
    for (p = 2; p * p <= top; p++) begin
      if (is_prime[p]) begin
        for (m = p * p; m <= top; m += p) is_prime[m] = 1'b0;
      end
    end
    md = 2;
    for (p = n + 1; p <= top; p++) begin
      if (is_prime[p]) begin
        md = p;
        break;
      end
    end
    ways[0] = 1 % md;
    for (j = 1; j <= n; j++) ways[j] = 0;
    for (p = 2; p <= n; p++) begin
      if (!is_prime[p] || p == n) continue;
      for (j = p; j <= n; j++) begin
        s = ways[j] + ways[j - p];
        if (s >= md) s -= md;
        ways[j] = s;
      end
    end
    a.target  = target;
    a.residue = (n == 0) ? '0 : ways[n][OUT_W-1:0];
    a.modulus = md[OUT_W-1:0];
    return a;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (answers.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT) begin
            $display("%0t: result residue %0d modulus %0d with no transaction waiting",
                     $time, count_residue_i, modulus_i);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          head = answers.pop_front();
          if (count_residue_i !== head.residue || modulus_i !== head.modulus) begin
            if (fail_count_o < REPORT_LIMIT) begin
              $display("%0t: target %0d: expected residue %0d modulus %0d, got %0d %0d",
                       $time, head.target, head.residue, head.modulus,
                       count_residue_i, modulus_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        answers.insert(answers.size(), count_prime_partitions(target_i));
      end
      pending_o <= answers.size();
    end
  end

endmodule

FILE: verif/tb_prime_partition_count_mod_core.sv
`timescale 1ns / 1ps

// Top of the prime partition counter bench. This module only produces
// stimulus and gives the verdict; prediction and comparison live in the
// checker instantiated beside the block.
module tb_prime_partition_count_mod_core;
  import ppc_pkg::*;

  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RANDOM_ITEMS  = 76;
  // Long enough for a result to sit in the output register while the next
  // target finishes, so that the input channel must stall.
  localparam int unsigned LONG_HOLD     = 20000;
  // Quiet time after the last result, to catch anything spurious.
  localparam int unsigned SETTLE_CYCLES = 2000;
  // Bound on the run length, set well above the work of the single largest
  // target and of the random part, even with every stall.
  localparam longint unsigned CYCLE_LIMIT = 30_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  logic [TARGET_W-1:0] target;
  logic                out_valid;
  logic                out_stall;
  logic [OUT_W-1:0]    count_residue;
  logic [OUT_W-1:0]    modulus;

  int              fail_count;
  int              pending;
  bit              long_hold_go;
  bit              long_hold_done;
  int unsigned     burst_left;
  longint unsigned cycles;

  prime_partition_count_mod_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .target_i        (target),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .count_residue_o (count_residue),
    .modulus_o       (modulus)
  );

  prime_partition_checker u_answer_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .target_i        (target),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .count_residue_i (count_residue),
    .modulus_i       (modulus),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 20 ns period, low half first so the first rising edge comes at 10 ns.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // A hung block must not run forever. Every correct run ends far below this.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_prime_partition_count_mod_core: done, errors");
      $finish;
    end
  end

  // Most random targets are small, since the work grows with the square of
  // n. A minority reach a few hundred to exercise longer table passes.
  function automatic logic [TARGET_W-1:0] pick_target();
    if ($urandom_range(0, 99) < 85) return TARGET_W'($urandom_range(0, 120));
    return TARGET_W'($urandom_range(121, 300));
  endfunction

  // Offers one target and returns at the falling edge after the transaction
  // was accepted. The sender runs in bursts: inside a burst valid stays high
  // from one transaction to the next, and between bursts it drops for a
  // random gap. Every assignment lands on a different falling edge, so valid
  // is never lowered and raised within one time step.
  task automatic send_target(input logic [TARGET_W-1:0] n);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(negedge clk_i);
      // Now and then a long burst gives a stretch with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    target   <= n;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Drops valid and waits until every accepted transaction has produced its
  // result. At least one falling edge passes before returning, so the next
  // raise of valid never shares a time step with this lowering.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  // Receiver: stalls follow a pattern of their own, in segments of random
  // length, each one either free flowing, lightly stalled, heavily stalled
  // or alternating. Once the random part has started it holds off for a long
  // stretch while the sender keeps going, so the block fills up and stalls
  // its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned seg;
    int unsigned k;
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(5, 60);
      for (k = 0; k < seg; k++) begin
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= (k % 3 == 0);
          end
        endcase
        @(negedge clk_i);
      end
    end
  end

  // Directed targets: the smallest values (zero, one and two, where no sum
  // of two primes exists), small primes, where the coin equal to n must be
  // left out, powers of two and their neighbors, and the largest value,
  // which also sets every bit of the field.
  initial begin : stimulus
    int unsigned directed [];
    int unsigned i;
    directed     = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12, 13,
                     17, 30, 31, 63, 64, 97, 127, 128, 255, 256,
                     4095};
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    target       = '0;
    long_hold_go = 1'b0;
    burst_left   = 0;
    cycles       = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_target(TARGET_W'(directed[i]));

    // The sender pauses here until the block has answered everything.
    drain();

    long_hold_go = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) send_target(pick_target());

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_prime_partition_count_mod_core: done, clean");
    end else begin
      $display("tb_prime_partition_count_mod_core: done, errors");
    end
    $finish;
  end

endmodule
